// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsc assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gsc assertion failed");

`endif

// ===== hw/rtl/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, widths and codes shared by the greedy set cover block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    // Default sizes of the element space and of the subset store.
    localparam int DEF_ELEMENTS = 64;
    localparam int DEF_SLOTS    = 32;

    // Field widths of the input and output words.
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 5;
    localparam int MASK_W  = 64;
    localparam int GAIN_W  = 7;
    localparam int CFG_W   = 6;

    // Largest number of slots a run may consider.
    localparam int MAX_RUN = 32;

    // Input word operation codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_UNIV = 2'd0,
        MODE_SLOT = 2'd1,
        MODE_RUN  = 2'd2
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_univ;
        logic ld_slot;
        logic run_start;
        logic scan_start;
        logic scan_issue;
        logic pick;
        logic emit_ok;
        logic emit_fail;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic univ_empty;
        logic limit_zero;
        logic scan_last;
        logic pipe_busy;
        logic best_zero;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/gsc_in_if.sv =====
// ----------------------------------------------------------------------------
// gsc_in_if
// Valid/ready channel that carries one input word of the cover engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsc_in_if
    import gsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
    logic [MASK_W-1:0] element_mask;

    modport source (output valid, output mode, output slot, output element_mask,
                    input ready);
    modport sink   (input valid, input mode, input slot, input element_mask,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gsc_out_if.sv =====
// ----------------------------------------------------------------------------
// gsc_out_if
// Valid/ready channel that carries one result word of the cover engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsc_out_if
    import gsc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] chosen_slot;
    logic [GAIN_W-1:0] gain;
    logic              done_res;
    logic              success;

    modport source (output valid, output chosen_slot, output gain, output done_res,
                    output success, input ready);
    modport sink   (input valid, input chosen_slot, input gain, input done_res,
                    input success, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/greedy_set_cover.sv =====
// Load words: the acknowledge word is valid in the cycle after the load word is accepted.
// Run: each pick scans L slots, L = min(subsets_in_use, SLOTS, 32), one slot per cycle
// through the single store read port, then drains the pipeline and emits the pick.
// The status word follows the last pick, from the check state, when the universe is covered,
// or follows one more scan when no slot adds an element.
// Synchronous active-low reset clears universe, used flags, slot count and output valid.
// ----------------------------------------------------------------------------
// greedy_set_cover
// Greedy set cover engine: loads a universe and subset masks, then picks
// the subset with the most uncovered elements until covered or stuck.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_set_cover
    import gsc_pkg::*;
#(
    parameter int ELEMENTS = DEF_ELEMENTS,
    parameter int SLOTS    = DEF_SLOTS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    gsc_in_if.sink                i_in,
    gsc_out_if.source             o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer.
    gsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_mode     (i_in.mode),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Storage, scan pipeline and result register.
    gsc_dp #(
        .ELEMENTS (ELEMENTS),
        .SLOTS    (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_slot        (i_in.slot),
        .i_mask        (i_in.element_mask),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_slot    (o_out.chosen_slot),
        .o_out_gain    (o_out.gain),
        .o_out_done    (o_out.done_res),
        .o_out_ok      (o_out.success)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsc_ctrl
// Controller of the cover engine: decodes input words and sequences the
// scan, pick and status steps of a run.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_ctrl
    import gsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    input  wire t_sts              i_sts,
    output logic                   o_in_ready,
    output t_cmd                   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Input words are taken only between runs and when the result slot frees.
    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    unique case (i_mode)
                        MODE_UNIV: begin
                            o_cmd.ld_univ = 1'b1;
                            o_cmd.emit_ok = 1'b1;
                        end
                        MODE_SLOT: begin
                            o_cmd.ld_slot = 1'b1;
                            o_cmd.emit_ok = 1'b1;
                        end
                        MODE_RUN: begin
                            o_cmd.run_start = 1'b1;
                            n_state         = S_CHECK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (i_sts.univ_empty) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_ok = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = i_sts.limit_zero ? S_EMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (i_sts.best_zero) begin
                        o_cmd.emit_fail = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.pick = 1'b1;
                        n_state    = S_CHECK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gsc_dp.sv =====
// ----------------------------------------------------------------------------
// gsc_dp
// Datapath of the cover engine: universe and used flags, the subset store,
// a scan pipeline of read and count stages that counts uncovered elements per slot, the
// best-slot tracker and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_dp
    import gsc_pkg::*;
#(
    parameter int ELEMENTS = DEF_ELEMENTS,
    parameter int SLOTS    = DEF_SLOTS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [MASK_W-1:0] i_mask,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [SLOT_W-1:0]      o_out_slot,
    output logic [GAIN_W-1:0]      o_out_gain,
    output logic                   o_out_done,
    output logic                   o_out_ok
);

    localparam int RUN_LIMIT = (SLOTS < MAX_RUN) ? SLOTS : MAX_RUN;
    localparam int SW        = $clog2(SLOTS);
    localparam int CW        = $clog2(RUN_LIMIT);
    localparam int LW        = $clog2(RUN_LIMIT + 1);
    localparam int GW        = $clog2(ELEMENTS + 1);

    // Count of set bits in a mask.
    function automatic logic [GW-1:0] f_popcount(input logic [ELEMENTS-1:0] v);
        logic [GW-1:0] n;
        n = '0;
        for (int i = 0; i < ELEMENTS; i++) begin
            n = n + GW'(v[i]);
        end
        return n;
    endfunction

    logic [CFG_W-1:0]    r_cfg;
    logic [LW-1:0]       r_limit;
    logic [ELEMENTS-1:0] r_univ;
    logic [RUN_LIMIT-1:0] r_used;
    logic [ELEMENTS-1:0] r_mem [SLOTS];
    logic [CW-1:0]       r_cnt;

    logic                r_s1_vld;
    logic                r_s1_skip;
    logic [CW-1:0]       r_s1_slot;
    logic [ELEMENTS-1:0] r_s1_data;

    logic                r_s2_vld;
    logic [GW-1:0]       r_s2_cnt;
    logic [CW-1:0]       r_s2_slot;
    logic [ELEMENTS-1:0] r_s2_data;

    logic [GW-1:0]       r_best_gain;
    logic [CW-1:0]       r_best_slot;
    logic [ELEMENTS-1:0] r_best_mask;

    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [GAIN_W-1:0]   r_out_gain;
    logic                r_out_done;
    logic                r_out_ok;

    // Status toward the controller.
    always_comb begin
        o_sts.univ_empty = (r_univ == '0);
        o_sts.limit_zero = (r_limit == '0);
        o_sts.scan_last  = (LW'(r_cnt) == r_limit - LW'(1));
        o_sts.pipe_busy  = r_s1_vld || r_s2_vld;
        o_sts.best_zero  = (r_best_gain == '0);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // Slot count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    // Run limit, universe and used flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '0;
            r_univ  <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.run_start) begin
                r_used  <= '0;
                r_limit <= (r_cfg > CFG_W'(RUN_LIMIT)) ? LW'(RUN_LIMIT) : LW'(r_cfg);
            end
            if (i_cmd.ld_univ) begin
                r_univ <= i_mask[ELEMENTS-1:0];
            end
            if (i_cmd.pick) begin
                r_univ              <= r_univ & ~r_best_mask;
                r_used[r_best_slot] <= 1'b1;
            end
        end
    end

    // Subset store: one write port for loads, one registered read for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_slot && (32'(i_slot) < SLOTS)) begin
            r_mem[SW'(i_slot)] <= i_mask[ELEMENTS-1:0];
        end
        if (i_cmd.scan_issue) begin
            r_s1_data <= r_mem[SW'(r_cnt)];
        end
    end

    // Scan address counter and first pipeline stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_start) begin
                r_cnt <= '0;
            end else if (i_cmd.scan_issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_s1_slot <= r_cnt;
            r_s1_skip <= r_used[r_cnt];
        end
    end

    // Second stage: uncovered element count, zero for a slot already used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_cnt  <= r_s1_skip ? '0 : f_popcount(r_s1_data & r_univ);
            r_s2_slot <= r_s1_slot;
            r_s2_data <= r_s1_data;
        end
    end

    // Best slot so far; a strict compare keeps the lowest slot on a tie.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_gain <= '0;
        end else if (i_cmd.scan_start) begin
            r_best_gain <= '0;
        end else if (r_s2_vld && (r_s2_cnt > r_best_gain)) begin
            r_best_gain <= r_s2_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld && (r_s2_cnt > r_best_gain)) begin
            r_best_slot <= r_s2_slot;
            r_best_mask <= r_s2_data;
        end
    end

    // Result register: holds one word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_ok || i_cmd.emit_fail || i_cmd.pick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_out_slot <= SLOT_W'(r_best_slot);
            r_out_gain <= GAIN_W'(r_best_gain);
            r_out_done <= 1'b0;
            r_out_ok   <= 1'b0;
        end else if (i_cmd.emit_ok || i_cmd.emit_fail) begin
            r_out_slot <= '0;
            r_out_gain <= '0;
            r_out_done <= 1'b1;
            r_out_ok   <= i_cmd.emit_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_slot  = r_out_slot;
    assign o_out_gain  = r_out_gain;
    assign o_out_done  = r_out_done;
    assign o_out_ok    = r_out_ok;

endmodule

`default_nettype wire

// ===== hw/rtl/gsc_checker.sv =====
// ----------------------------------------------------------------------------
// gsc_checker
// Port-level checks on the result channel of the cover engine.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gsc_checker
    import gsc_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              i_ready,
    input wire logic [SLOT_W-1:0] i_slot,
    input wire logic [GAIN_W-1:0] i_gain,
    input wire logic              i_done,
    input wire logic              i_ok
);

    // A stalled result word stays put.
    `GSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable({i_slot, i_gain, i_done, i_ok}))

    // A pick word always covers at least one element.
    `GSC_ASSERT_NOW(a_pick_gain, i_clk, i_rst_n, i_valid && !i_done, i_gain != '0)

    // A pick word never claims success.
    `GSC_ASSERT_NOW(a_pick_ok, i_clk, i_rst_n, i_valid && !i_done, !i_ok)

    // Status and acknowledge words carry no slot and no gain.
    `GSC_ASSERT_NOW(a_status_zero, i_clk, i_rst_n, i_valid && i_done, (i_gain == '0) && (i_slot == '0))

endmodule

bind greedy_set_cover gsc_checker u_gsc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_slot  (o_out.chosen_slot),
    .i_gain  (o_out.gain),
    .i_done  (o_out.done_res),
    .i_ok    (o_out.success)
);

`default_nettype wire
